// ===== hdl/triangle_radius_ratio_macros.svh =====
// assertion macros for the triangle radius-ratio block
`ifndef TRIANGLE_RADIUS_RATIO_MACROS_SVH
`define TRIANGLE_RADIUS_RATIO_MACROS_SVH

// implication in the same cycle, off during reset
`define TRR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication into the next cycle, off during reset
`define TRR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// what must hold in the cycle after reset is seen
`define TRR_ASSERT_RESET(label, clk, rstn, cons, msg) \
    label: assert property (@(posedge clk) (!rstn) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/trr_pkg.sv =====
// types, constants and arithmetic helpers for the radius-ratio pipeline
package trr_pkg;

    localparam int CW      = 16;
    localparam int IN_W    = 6 * CW;
    localparam int DW      = CW + 1;
    localparam int PW      = 2 * DW;
    localparam int LW      = 34;
    localparam int RW      = 62;
    localparam int SQ_BITS = 31;
    localparam int SQ_PER  = 4;
    localparam int SQ_ST   = (SQ_BITS + SQ_PER - 1) / SQ_PER;
    localparam int MW      = 32;
    localparam int DV_PER  = 4;
    localparam int DV_ST   = MW / DV_PER;
    localparam int EW      = 10;
    localparam int RATIO_W = 16;
    localparam int PIPE    = 4 + SQ_ST + 6 + DV_ST + 1;
    localparam int LANES   = 3;

    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

    typedef logic signed [EW-1:0] exp_t;

    typedef struct packed {
        logic [MW-1:0] m;
        exp_t          e;
    } fnum_t;

    typedef struct packed {
        logic [MW:0]        rem;
        logic [SQ_BITS-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [MW-1:0] rem;
        logic [MW-1:0] q;
    } dv_t;

    typedef struct packed {
        logic  deg;
        fnum_t num;
    } side_t;

    function automatic logic [5:0] msb_pos(logic [LW-1:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < LW; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    function automatic fnum_t mul_norm(logic [2*MW-1:0] pr, exp_t es);
        fnum_t r;
        if (pr[2*MW-1]) begin
            r.m = pr[2*MW-1:MW];
            r.e = es + exp_t'(MW);
        end else begin
            r.m = pr[2*MW-2:MW-1];
            r.e = es + exp_t'(MW - 1);
        end
        return r;
    endfunction

    function automatic fnum_t fadd(fnum_t a, fnum_t b);
        fnum_t       x;
        fnum_t       y;
        fnum_t       r;
        exp_t        d;
        logic [MW-1:0] ys;
        logic [MW:0]   s;
        if (b.e > a.e) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        d  = x.e - y.e;
        ys = (d >= exp_t'(MW)) ? '0 : (y.m >> d);
        s  = {1'b0, x.m} + {1'b0, ys};
        if (s[MW]) begin
            r.m = s[MW:1];
            r.e = x.e + exp_t'(1);
        end else begin
            r.m = s[MW-1:0];
            r.e = x.e;
        end
        return r;
    endfunction

    function automatic sq_t sq_step(sq_t x, logic [1:0] pr);
        sq_t         r;
        logic [MW+2:0] w;
        logic [MW+2:0] t;
        w = {x.rem, pr};
        t = {2'b00, x.root, 2'b01};
        if (w >= t) begin
            w      = w - t;
            r.root = {x.root[SQ_BITS-2:0], 1'b1};
        end else begin
            r.root = {x.root[SQ_BITS-2:0], 1'b0};
        end
        r.rem = w[MW:0];
        return r;
    endfunction

    function automatic dv_t dv_step(dv_t x, logic b, logic [MW-1:0] den);
        dv_t       r;
        logic [MW:0] w;
        w = {x.rem, b};
        if (w >= {1'b0, den}) begin
            w   = w - {1'b0, den};
            r.q = {x.q[MW-2:0], 1'b1};
        end else begin
            r.q = {x.q[MW-2:0], 1'b0};
        end
        r.rem = w[MW-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/triangle_radius_ratio.sv =====
// triangle quality 2r/R pipeline: diffs, products, roots, products, divide
//
//  channel | ports          | tdata fields (low bit up)        | tuser
//  --------+----------------+----------------------------------+-----------
//  input   | s_tvalid/ready | ax, ay, bx, by, cx, cy (16b each)| -
//  result  | m_tvalid/ready | ratio (16b)                      | degenerate
//
//  one item accepted per cycle while the result side is not stalled
//  the three 31-step square-root lanes and the 32-step divider are each
//  cut into four steps per stage
//  aresetn clears the valid bits only; the data path carries no reset
//  a stall on the result side freezes every stage; nothing is lost
module triangle_radius_ratio (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [trr_pkg::IN_W-1:0]   s_tdata,   // ax, ay, bx, by, cx, cy
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [trr_pkg::RATIO_W-1:0] m_tdata,  // ratio
    output logic                       m_tuser    // degenerate
);
    import trr_pkg::*;

    logic             ce;
    logic [PIPE-1:0]  vld_reg;
    logic [PIPE-1:0]  vld_next;

    logic signed [CW-1:0] ax, ay, bx, by, cx, cy;

    // stage 1
    logic signed [DW-1:0] dbax_reg, dbay_reg, dcax_reg, dcay_reg, dbcx_reg, dbcy_reg;
    // stage 2
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic signed [PW-1:0] esq_reg [2*LANES];
    // stage 3
    logic signed [PW:0]   d_reg;
    logic [LW-1:0]        l2_reg [LANES];
    // stage 4 and root lanes
    sq_t                  sq_reg   [SQ_ST+1][LANES];
    sq_t                  sq_next  [1:SQ_ST][LANES];
    logic [RW-1:0]        sv_reg   [SQ_ST+1][LANES];
    exp_t                 se_reg   [SQ_ST+1][LANES];
    side_t                side_reg [SQ_ST+1];
    // product stages
    logic [2*MW-1:0]      pab_raw_reg, num_raw_reg, pcs_raw_reg, den_raw_reg;
    exp_t                 pab_e_reg, num_e_reg, pcs_e_reg, den_e_reg;
    fnum_t                s1_reg, s2_reg, ec1_reg, ec2_reg;
    fnum_t                pab_reg, pab3_reg, pab4_reg;
    fnum_t                pcs_reg;
    fnum_t                num2_reg, num3_reg, num4_reg, num5_reg;
    logic                 deg_t_reg [5];
    // divider
    dv_t                  dv_reg   [DV_ST+1];
    dv_t                  dv_next  [1:DV_ST];
    logic [MW-1:0]        dden_reg [DV_ST+1];
    exp_t                 sh_reg   [DV_ST+1];
    logic                 ddeg_reg [DV_ST+1];
    logic                 lsb0_reg;
    // output
    logic [RATIO_W-1:0]   ratio_reg, ratio_next;
    logic                 deg_out_reg;

    // stage 4 combinational
    logic [PW:0]          d_abs;
    logic [LW-1:0]        ad;
    logic [5:0]           ad_p;
    fnum_t                num_n;
    logic [5:0]           lp   [LANES];
    logic [4:0]           lk   [LANES];
    logic [RW-1:0]        lv   [LANES];
    exp_t                 le   [LANES];

    fnum_t                ea, eb, ec, den_n;

    assign ax = signed'(s_tdata[0*CW +: CW]);
    assign ay = signed'(s_tdata[1*CW +: CW]);
    assign bx = signed'(s_tdata[2*CW +: CW]);
    assign by = signed'(s_tdata[3*CW +: CW]);
    assign cx = signed'(s_tdata[4*CW +: CW]);
    assign cy = signed'(s_tdata[5*CW +: CW]);

    assign ce       = !vld_reg[PIPE-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[PIPE-1];
    assign m_tdata  = ratio_reg;
    assign m_tuser  = deg_out_reg;

    assign vld_next = {vld_reg[PIPE-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= vld_next;
        end
    end

    always_comb begin
        d_abs = (d_reg < 0) ? unsigned'(-d_reg) : unsigned'(d_reg);
        ad    = d_abs[LW-1:0];
        ad_p  = msb_pos(ad);
        if (ad_p >= 6'(MW - 1)) begin
            num_n.m = MW'(ad >> (ad_p - 6'(MW - 1)));
        end else begin
            num_n.m = MW'(ad << (6'(MW - 1) - ad_p));
        end
        num_n.e = exp_t'(int'(ad_p)) - exp_t'(MW - 1);
        for (int l = 0; l < LANES; l++) begin
            lp[l] = msb_pos(l2_reg[l]);
            lk[l] = 5'((RW - 1 - int'(lp[l])) >> 1);
            lv[l] = {{(RW-LW){1'b0}}, l2_reg[l]} << {lk[l], 1'b0};
            le[l] = -exp_t'(int'(lk[l])) - exp_t'(1);
        end
    end

    // root lanes, four digits a stage
    always_comb begin
        int g;
        int i;
        for (int s = 1; s <= SQ_ST; s++) begin
            for (int l = 0; l < LANES; l++) begin
                sq_next[s][l] = sq_reg[s-1][l];
                for (int j = 0; j < SQ_PER; j++) begin
                    g = (s - 1) * SQ_PER + j;
                    i = (g < SQ_BITS) ? (SQ_BITS - 1 - g) : 0;
                    if (g < SQ_BITS) begin
                        sq_next[s][l] = sq_step(sq_next[s][l], sv_reg[s-1][l][2*i +: 2]);
                    end
                end
            end
        end
    end

    assign ea = '{m: {sq_reg[SQ_ST][0].root, 1'b0}, e: se_reg[SQ_ST][0]};
    assign eb = '{m: {sq_reg[SQ_ST][1].root, 1'b0}, e: se_reg[SQ_ST][1]};
    assign ec = '{m: {sq_reg[SQ_ST][2].root, 1'b0}, e: se_reg[SQ_ST][2]};

    assign den_n = mul_norm(den_raw_reg, den_e_reg);

    // divider, four quotient bits a stage
    always_comb begin
        int g;
        for (int s = 1; s <= DV_ST; s++) begin
            dv_next[s] = dv_reg[s-1];
            for (int j = 0; j < DV_PER; j++) begin
                g = (s - 1) * DV_PER + j;
                dv_next[s] = dv_step(dv_next[s], (g == 0) ? lsb0_reg : 1'b0, dden_reg[s-1]);
            end
        end
    end

    always_comb begin
        exp_t          n;
        logic [MW-1:0] shifted;
        n       = -sh_reg[DV_ST];
        shifted = dv_reg[DV_ST].q >> n;
        priority if (ddeg_reg[DV_ST]) begin
            ratio_next = '0;
        end else if (sh_reg[DV_ST] >= 0) begin
            ratio_next = RATIO_MAX;
        end else if (n >= exp_t'(MW)) begin
            ratio_next = '0;
        end else if (|shifted[MW-1:RATIO_W]) begin
            ratio_next = RATIO_MAX;
        end else begin
            ratio_next = shifted[RATIO_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            // edge differences
            dbax_reg <= DW'(bx) - DW'(ax);
            dbay_reg <= DW'(by) - DW'(ay);
            dcax_reg <= DW'(cx) - DW'(ax);
            dcay_reg <= DW'(cy) - DW'(ay);
            dbcx_reg <= DW'(bx) - DW'(cx);
            dbcy_reg <= DW'(by) - DW'(cy);
            // cross terms and squares
            p1_reg     <= PW'(dbax_reg) * PW'(dcay_reg);
            p2_reg     <= PW'(dbay_reg) * PW'(dcax_reg);
            esq_reg[0] <= PW'(dbcx_reg) * PW'(dbcx_reg);
            esq_reg[1] <= PW'(dbcy_reg) * PW'(dbcy_reg);
            esq_reg[2] <= PW'(dcax_reg) * PW'(dcax_reg);
            esq_reg[3] <= PW'(dcay_reg) * PW'(dcay_reg);
            esq_reg[4] <= PW'(dbax_reg) * PW'(dbax_reg);
            esq_reg[5] <= PW'(dbay_reg) * PW'(dbay_reg);
            // twice the area and squared lengths
            d_reg <= (PW+1)'(p1_reg) - (PW+1)'(p2_reg);
            for (int l = 0; l < LANES; l++) begin
                l2_reg[l] <= unsigned'(esq_reg[2*l] + esq_reg[2*l+1]);
            end
            // normalise
            side_reg[0].deg <= (d_reg == '0);
            side_reg[0].num <= num_n;
            for (int l = 0; l < LANES; l++) begin
                sq_reg[0][l] <= '0;
                sv_reg[0][l] <= lv[l];
                se_reg[0][l] <= le[l];
            end
            for (int s = 1; s <= SQ_ST; s++) begin
                side_reg[s] <= side_reg[s-1];
                for (int l = 0; l < LANES; l++) begin
                    sq_reg[s][l] <= sq_next[s][l];
                    sv_reg[s][l] <= sv_reg[s-1][l];
                    se_reg[s][l] <= se_reg[s-1][l];
                end
            end
            // products and sums
            pab_raw_reg  <= {{MW{1'b0}}, ea.m} * {{MW{1'b0}}, eb.m};
            pab_e_reg    <= ea.e + eb.e;
            s1_reg       <= fadd(ea, eb);
            ec1_reg      <= ec;
            num_raw_reg  <= {{MW{1'b0}}, side_reg[SQ_ST].num.m} *
                            {{MW{1'b0}}, side_reg[SQ_ST].num.m};
            num_e_reg    <= side_reg[SQ_ST].num.e + side_reg[SQ_ST].num.e;
            deg_t_reg[0] <= side_reg[SQ_ST].deg;

            pab_reg      <= mul_norm(pab_raw_reg, pab_e_reg);
            s2_reg       <= fadd(s1_reg, ec1_reg);
            ec2_reg      <= ec1_reg;
            num2_reg     <= mul_norm(num_raw_reg, num_e_reg + exp_t'(2));
            deg_t_reg[1] <= deg_t_reg[0];

            pcs_raw_reg  <= {{MW{1'b0}}, ec2_reg.m} * {{MW{1'b0}}, s2_reg.m};
            pcs_e_reg    <= ec2_reg.e + s2_reg.e;
            pab3_reg     <= pab_reg;
            num3_reg     <= num2_reg;
            deg_t_reg[2] <= deg_t_reg[1];

            pcs_reg      <= mul_norm(pcs_raw_reg, pcs_e_reg);
            pab4_reg     <= pab3_reg;
            num4_reg     <= num3_reg;
            deg_t_reg[3] <= deg_t_reg[2];

            den_raw_reg  <= {{MW{1'b0}}, pab4_reg.m} * {{MW{1'b0}}, pcs_reg.m};
            den_e_reg    <= pab4_reg.e + pcs_reg.e;
            num5_reg     <= num4_reg;
            deg_t_reg[4] <= deg_t_reg[3];

            // divider set-up
            dv_reg[0]   <= '{rem: {1'b0, num5_reg.m[MW-1:1]}, q: '0};
            lsb0_reg    <= num5_reg.m[0];
            dden_reg[0] <= den_n.m;
            sh_reg[0]   <= num5_reg.e - den_n.e - exp_t'(15);
            ddeg_reg[0] <= deg_t_reg[4];
            for (int s = 1; s <= DV_ST; s++) begin
                dv_reg[s]   <= dv_next[s];
                dden_reg[s] <= dden_reg[s-1];
                sh_reg[s]   <= sh_reg[s-1];
                ddeg_reg[s] <= ddeg_reg[s-1];
            end
            // result
            ratio_reg   <= ratio_next;
            deg_out_reg <= ddeg_reg[DV_ST];
        end
    end

endmodule

// ===== hdl/trr_checker.sv =====
// port-level checks for the radius-ratio block, bound to the top level
`include "triangle_radius_ratio_macros.svh"

module trr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [trr_pkg::RATIO_W-1:0] m_tdata,
    input logic                        m_tuser
);
    import trr_pkg::*;

    `TRR_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result item dropped while stalled")
    `TRR_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")
    `TRR_ASSERT_SAME(a_deg_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0, "degenerate item with nonzero ratio")
    `TRR_ASSERT_SAME(a_ready_empty, aclk, aresetn, !m_tvalid, s_tready, "input blocked with empty output")
    `TRR_ASSERT_RESET(a_reset_empty, aclk, aresetn, !m_tvalid, "result valid after reset")

endmodule

bind triangle_radius_ratio trr_checker u_trr_checker (.*);
